// ===== hw/rtl/rhcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhcc_pkg
// Shared types and constants for the RGB/HSL color converter.
// ----------------------------------------------------------------------------
package rhcc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HUE_BITS  = FRAC_BITS - 3;
  localparam int FIELD_W   = 16;
  localparam int DATA_W    = 4 * FIELD_W;

  // fixed-point constants
  localparam logic [16:0] ONE_FX    = 17'd65536;
  localparam logic [17:0] TWO_FX    = 18'd131072;
  localparam logic [15:0] HALF_FX   = 16'd32768;
  localparam logic [15:0] HUE_TWO   = 16'd16384;
  localparam logic [15:0] HUE_FOUR  = 16'd32768;
  localparam logic [15:0] HUE_SIX   = 16'd49152;
  localparam logic [16:0] HUE_ONE_T = 17'd8192;
  localparam logic [16:0] HUE_3_T   = 17'd24576;
  localparam logic [16:0] HUE_4_T   = 17'd32768;
  localparam logic [17:0] HUE_SIX_S = 18'sd49152;

  localparam int SAT_STEPS = 17;  // quotient bits of saturation
  localparam int HUE_STEPS = 14;  // quotient bits of hue fraction
  localparam int DIV_FIRST = 3;   // pipeline index of the first divider stage
  localparam int NUM_STG   = DIV_FIRST + SAT_STEPS;

  localparam logic DIR_TO_HSL = 1'b0;
  localparam logic DIR_TO_RGB = 1'b1;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } hue_seg_t;

  typedef struct packed {
    logic                  dir;
    logic [15:0]           alpha;
    logic [15:0]           in0;
    logic [15:0]           in1;
    logic [15:0]           in2;
    // RGB to HSL
    logic [15:0]           light;
    logic                  gray;
    max_sel_t              sel;
    logic                  hneg;
    logic [15:0]           hmag;
    logic [16:0]           sum;
    logic [15:0]           delta;
    logic [16:0]           den;
    logic [17:0]           srem;
    logic [16:0]           sq;
    logic [16:0]           hrem;
    logic [13:0]           hq;
    // HSL to RGB
    logic [15:0]           ls;
    logic [16:0]           qv;
    logic [16:0]           pv;
    logic [17:0]           dqp;
    logic [2:0][1:0]       seg;
    logic [2:0][13:0]      mop;
    logic [2:0][31:0]      prod;
    logic [2:0][16:0]      chan;
  } pipe_t;

endpackage

// ===== hw/rtl/rgb_hsl_color_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter_unit
// Pipelined RGB <-> HSL converter, one pixel per clock when not stalled.
// ----------------------------------------------------------------------------
// Input beats on in_* carry three components and alpha; output beats on out_*
// carry the converted components and the same alpha. cfg_wr_en/cfg_wr_data
// set the direction (0: RGB to HSL, 1: HSL to RGB); write it while idle.
// The datapath is 20 register stages (st_r) plus an output register.
// Throughput is one beat per cycle while out_tready keeps the output
// moving; the 17 restoring divider stages for saturation and hue set the
// depth, one quotient bit per stage.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output fills bubbles first and then holds in_tready low; nothing
// is dropped or repeated. Reset clears all valid bits and sets the
// direction to RGB to HSL.
// ----------------------------------------------------------------------------
module rgb_hsl_color_converter_unit
  import rhcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  // comp_first, comp_second, comp_third, alpha_in
  input  logic [DATA_W-1:0] in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // res_first, res_second, res_third, alpha_out
  output logic [DATA_W-1:0] out_tdata
);

  logic              dir_r;
  pipe_t             st_r   [NUM_STG];
  pipe_t             st_nxt [NUM_STG];
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG:0]   adv;
  logic              out_vld_r;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_TO_HSL;
    end else if (cfg_wr_en) begin
      dir_r <= cfg_wr_data;
    end
  end

  assign adv[NUM_STG] = !out_vld_r || out_tready;
  for (genvar k = 0; k < NUM_STG; k++) begin : g_adv
    assign adv[k] = !vld_r[k] || adv[k+1];
  end
  assign in_tready = adv[0];

  always_comb begin
    st_nxt[0]       = '0;
    st_nxt[0].dir   = dir_r;
    st_nxt[0].in0   = in_tdata[15:0];
    st_nxt[0].in1   = in_tdata[31:16];
    st_nxt[0].in2   = in_tdata[47:32];
    st_nxt[0].alpha = in_tdata[63:48];
  end

  for (genvar k = 1; k < NUM_STG; k++) begin : g_stg
    localparam int J  = k - DIV_FIRST;
    localparam int HJ = J - (SAT_STEPS - HUE_STEPS);
    if (k == 1) begin : g_a
      logic [15:0] mx, mn;
      logic [31:0] lsp;
      always_comb begin
        st_nxt[k] = st_r[k-1];
        mx = st_r[k-1].in0;
        mn = st_r[k-1].in0;
        if (st_r[k-1].in1 > mx) mx = st_r[k-1].in1;
        if (st_r[k-1].in2 > mx) mx = st_r[k-1].in2;
        if (st_r[k-1].in1 < mn) mn = st_r[k-1].in1;
        if (st_r[k-1].in2 < mn) mn = st_r[k-1].in2;
        st_nxt[k].sum   = {1'b0, mx} + {1'b0, mn};
        st_nxt[k].delta = mx - mn;
        st_nxt[k].gray  = (mx == mn);
        st_nxt[k].light = st_nxt[k].sum[16:1];
        priority if (st_r[k-1].in0 >= mx) begin
          st_nxt[k].sel  = MAX_RED;
          st_nxt[k].hneg = st_r[k-1].in1 < st_r[k-1].in2;
          st_nxt[k].hmag = st_nxt[k].hneg ? st_r[k-1].in2 - st_r[k-1].in1
                                          : st_r[k-1].in1 - st_r[k-1].in2;
        end else if (st_r[k-1].in1 >= mx) begin
          st_nxt[k].sel  = MAX_GREEN;
          st_nxt[k].hneg = st_r[k-1].in2 < st_r[k-1].in0;
          st_nxt[k].hmag = st_nxt[k].hneg ? st_r[k-1].in0 - st_r[k-1].in2
                                          : st_r[k-1].in2 - st_r[k-1].in0;
        end else begin
          st_nxt[k].sel  = MAX_BLUE;
          st_nxt[k].hneg = st_r[k-1].in0 < st_r[k-1].in1;
          st_nxt[k].hmag = st_nxt[k].hneg ? st_r[k-1].in1 - st_r[k-1].in0
                                          : st_r[k-1].in0 - st_r[k-1].in1;
        end
        lsp = st_r[k-1].in2 * st_r[k-1].in1;
        st_nxt[k].ls = lsp[31:16];
      end
    end else if (k == 2) begin : g_b
      logic signed [17:0] t;
      logic        [16:0] tu;
      logic        [16:0] lw;
      always_comb begin
        st_nxt[k] = st_r[k-1];
        lw = {1'b0, st_r[k-1].in2};
        if (st_r[k-1].sum > ONE_FX) begin
          st_nxt[k].den = 17'(TWO_FX - {1'b0, st_r[k-1].sum});
        end else begin
          st_nxt[k].den = st_r[k-1].sum;
        end
        st_nxt[k].srem = {2'b0, st_r[k-1].delta};
        st_nxt[k].hrem = {1'b0, st_r[k-1].hmag};
        st_nxt[k].sq   = '0;
        st_nxt[k].hq   = '0;
        if (st_r[k-1].in2 < HALF_FX) begin
          st_nxt[k].qv = lw + {1'b0, st_r[k-1].ls};
        end else begin
          st_nxt[k].qv = lw + {1'b0, st_r[k-1].in1} - {1'b0, st_r[k-1].ls};
        end
        st_nxt[k].pv  = {st_r[k-1].in2, 1'b0} - st_nxt[k].qv;
        st_nxt[k].dqp = {17'(st_nxt[k].qv - lw), 1'b0};
        t  = '0;
        tu = '0;
        for (int i = 0; i < 3; i++) begin
          t = $signed({2'b0, st_r[k-1].in0});
          if (i == 0) t = t + $signed({2'b0, HUE_TWO});
          if (i == 2) t = t - $signed({2'b0, HUE_TWO});
          if (t < 0) begin
            t = t + HUE_SIX_S;
          end else if (t > HUE_SIX_S) begin
            t = t - HUE_SIX_S;
          end
          tu = t[16:0];
          st_nxt[k].mop[i] = '0;
          priority if (tu < HUE_ONE_T) begin
            st_nxt[k].seg[i] = SEG_RISE;
            st_nxt[k].mop[i] = tu[13:0];
          end else if (tu < HUE_3_T) begin
            st_nxt[k].seg[i] = SEG_HIGH;
          end else if (tu < HUE_4_T) begin
            st_nxt[k].seg[i] = SEG_FALL;
            st_nxt[k].mop[i] = 14'(HUE_4_T - tu);
          end else begin
            st_nxt[k].seg[i] = SEG_LOW;
          end
        end
      end
    end else begin : g_div
      logic [17:0] srem;
      logic [16:0] hrem;
      logic        sbit, hbit;
      always_comb begin
        st_nxt[k] = st_r[k-1];
        srem = (J == 0) ? st_r[k-1].srem : {st_r[k-1].srem[16:0], 1'b0};
        sbit = srem >= {1'b0, st_r[k-1].den};
        if (sbit) srem = srem - {1'b0, st_r[k-1].den};
        st_nxt[k].srem = srem;
        st_nxt[k].sq   = {st_r[k-1].sq[15:0], sbit};
        hrem = '0;
        hbit = 1'b0;
        if (HJ >= 0) begin
          hrem = (HJ == 0) ? st_r[k-1].hrem : {st_r[k-1].hrem[15:0], 1'b0};
          hbit = hrem >= {1'b0, st_r[k-1].delta};
          if (hbit) hrem = hrem - {1'b0, st_r[k-1].delta};
          st_nxt[k].hrem = hrem;
          st_nxt[k].hq   = {st_r[k-1].hq[12:0], hbit};
        end
        if (J == 0) begin
          for (int i = 0; i < 3; i++) begin
            st_nxt[k].prod[i] = st_r[k-1].dqp * st_r[k-1].mop[i];
          end
        end
        if (J == 1) begin
          for (int i = 0; i < 3; i++) begin
            unique case (hue_seg_t'(st_r[k-1].seg[i]))
              SEG_RISE, SEG_FALL:
                st_nxt[k].chan[i] = 17'(st_r[k-1].pv + st_r[k-1].prod[i][31:HUE_BITS]);
              SEG_HIGH: st_nxt[k].chan[i] = st_r[k-1].qv;
              SEG_LOW:  st_nxt[k].chan[i] = st_r[k-1].pv;
              default:  st_nxt[k].chan[i] = st_r[k-1].pv;
            endcase
          end
        end
      end
    end
  end

  for (genvar k = 0; k < NUM_STG; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_r[k] <= (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // final assembly
  logic [15:0] hue, sat, r0, r1, r2;
  pipe_t       fin;
  always_comb begin
    fin = st_r[NUM_STG-1];
    unique case (fin.sel)
      MAX_RED:   hue = (fin.hneg && fin.hq != '0) ? HUE_SIX - {2'b0, fin.hq}
                                                  : {2'b0, fin.hq};
      MAX_GREEN: hue = fin.hneg ? HUE_TWO - {2'b0, fin.hq} : HUE_TWO + {2'b0, fin.hq};
      MAX_BLUE:  hue = fin.hneg ? HUE_FOUR - {2'b0, fin.hq} : HUE_FOUR + {2'b0, fin.hq};
      default:   hue = '0;
    endcase
    sat = fin.sq[16] ? 16'hFFFF : fin.sq[15:0];
    if (fin.dir == DIR_TO_HSL) begin
      r0 = fin.gray ? 16'd0 : hue;
      r1 = fin.gray ? 16'd0 : sat;
      r2 = fin.light;
    end else if (fin.in1 == '0) begin
      r0 = fin.in2;
      r1 = fin.in2;
      r2 = fin.in2;
    end else if (fin.in2 == '0) begin
      r0 = '0;
      r1 = '0;
      r2 = '0;
    end else begin
      r0 = fin.chan[0][16] ? 16'hFFFF : fin.chan[0][15:0];
      r1 = fin.chan[1][16] ? 16'hFFFF : fin.chan[1][15:0];
      r2 = fin.chan[2][16] ? 16'hFFFF : fin.chan[2][15:0];
    end
    out_data_nxt = {fin.alpha, r2, r1, r0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv[NUM_STG]) begin
      out_vld_r <= vld_r[NUM_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NUM_STG]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== test/tb_rgb_hsl_color_converter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_hsl_color_converter_unit
// Sends RGB and HSL pixels through the converter in both directions. A
// predictor computes each expected pixel, and every output beat is checked
// against it, with random input and output stalls in all runs but the last.
// ----------------------------------------------------------------------------
module tb_rgb_hsl_color_converter_unit;
  import rhcc_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_wr_data = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;

  logic [DATA_W-1:0] pixel_q[$];
  logic              dir_r = DIR_TO_HSL;
  logic              gaps_on = 1'b1;
  int                n_err = 0;
  int                n_beats = 0;
  int                n_dir[2] = '{0, 0};

  localparam longint ONE = 64'sd1 << FRAC_BITS;
  localparam longint HONE = 64'sd1 << HUE_BITS;

  rgb_hsl_color_converter_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] sat16(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic longint div_tz(longint num, longint den);
    longint m;
    m = num < 0 ? -num : num;
    m = (m <<< HUE_BITS) / den;
    return num < 0 ? -m : m;
  endfunction

  function automatic longint mul_tz(longint a, longint t);
    longint m;
    m = a < 0 ? -a : a;
    m = (m * t) >>> HUE_BITS;
    return a < 0 ? -m : m;
  endfunction

  function automatic logic [DATA_W-1:0] convert_pixel(logic d, logic [DATA_W-1:0] px);
    longint a, b, c, mx, mn, sum, dl, den, h, q, p, t, v;
    logic [2:0][15:0] r;
    a = px[15:0];
    b = px[31:16];
    c = px[47:32];
    if (d == DIR_TO_HSL) begin
      mx = a; mn = a;
      if (b > mx) mx = b;
      if (c > mx) mx = c;
      if (b < mn) mn = b;
      if (c < mn) mn = c;
      sum = mx + mn;
      dl = mx - mn;
      r[2] = sat16(sum >>> 1);
      if (dl == 0) begin
        r[0] = '0; r[1] = '0;
      end else begin
        den = (sum > ONE) ? 2 * ONE - sum : sum;
        r[1] = (den <= 0) ? 16'hFFFF : sat16((dl <<< FRAC_BITS) / den);
        if (a >= mx) begin
          h = div_tz(b - c, dl);
          if (h < 0) h += 6 * HONE;
        end else if (b >= mx) begin
          h = 2 * HONE + div_tz(c - a, dl);
        end else begin
          h = 4 * HONE + div_tz(a - b, dl);
        end
        r[0] = sat16(h);
      end
    end else if (b == 0) begin
      r = {3{sat16(c)}};
    end else if (c == 0) begin
      r = '0;
    end else begin
      if (c < ONE / 2) q = (c * (ONE + b)) >>> FRAC_BITS;
      else q = c + b - ((c * b) >>> FRAC_BITS);
      p = 2 * c - q;
      for (int i = 0; i < 3; i++) begin
        t = a + (2 - 2 * i) * HONE;
        if (t < 0) t += 6 * HONE;
        else if (t > 6 * HONE) t -= 6 * HONE;
        if (t < HONE) v = p + mul_tz(q - p, t);
        else if (t < 3 * HONE) v = q;
        else if (t < 4 * HONE) v = p + mul_tz(q - p, 4 * HONE - t);
        else v = p;
        r[i] = sat16(v);
      end
    end
    return {px[63:48], r[2], r[1], r[0]};
  endfunction

  task automatic idle_burst();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic send_pixel(logic [15:0] f0, logic [15:0] f1, logic [15:0] f2,
                            logic [15:0] al);
    idle_burst();
    in_tdata  <= {al, f2, f1, f0};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixel_q.push_back(convert_pixel(dir_r, {al, f2, f1, f0}));
    n_dir[dir_r]++;
    @(negedge clk);
  endtask

  task automatic set_direction(logic d);
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dir_r = d;
  endtask

  function automatic logic [15:0] rnd_field();
    unique case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(16'h8000 + $urandom_range(0, 3) - 2);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic test_rgb_directed();
    set_direction(DIR_TO_HSL);
    send_pixel(0, 0, 0, 0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 0, 0, 16'h1234);
    send_pixel(0, 16'hFFFF, 0, 16'h8000);
    send_pixel(0, 0, 16'hFFFF, 16'h0001);
    send_pixel(16'hFFFF, 0, 16'h0001, 16'h5555);
    send_pixel(16'hFFFF, 16'hFFFF, 0, 16'hAAAA);
    send_pixel(16'h8000, 16'h8000, 16'h4000, 16'h7FFF);
    send_pixel(16'hFFFF, 16'hFFFE, 16'hFFFF, 0);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
  endtask

  task automatic test_hsl_directed();
    set_direction(DIR_TO_RGB);
    send_pixel(16'h1000, 0, 16'h8000, 16'h4321);
    send_pixel(16'h1000, 16'hFFFF, 0, 0);
    send_pixel(0, 16'hFFFF, 16'h8000, 16'hFFFF);
    send_pixel(16'hC000, 16'hFFFF, 16'h7FFF, 1);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 2);
    send_pixel(16'h2000, 16'h8000, 16'h4000, 3);
    send_pixel(16'h6000, 16'h8000, 16'hC000, 4);
    send_pixel(16'h5FFF, 16'h0001, 16'h0001, 5);
    send_pixel(16'hD000, 16'h4000, 16'hF000, 6);
    send_pixel(16'h4000, 16'hFFFF, 16'hFFFF, 7);
  endtask

  task automatic test_random(logic d, int n);
    set_direction(d);
    for (int i = 0; i < n; i++) begin
      if (d == DIR_TO_RGB && $urandom_range(0, 3) != 0)
        send_pixel(16'($urandom_range(0, 16'hC000)), rnd_field(), rnd_field(),
                   16'($urandom_range(0, 65535)));
      else
        send_pixel(rnd_field(), rnd_field(), rnd_field(), 16'($urandom_range(0, 65535)));
    end
  endtask

  always @(negedge clk) begin
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    logic [DATA_W-1:0] exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      n_beats++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_tdata);
        n_err++;
      end else begin
        exp_px = pixel_q.pop_front();
        for (int f = 0; f < 4; f++)
          if (exp_px[16*f+:16] !== out_tdata[16*f+:16]) begin
            $display("%0t: field %0d expected %h actual %h", $time, f,
                     exp_px[16*f+:16], out_tdata[16*f+:16]);
            n_err++;
          end
      end
    end
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_rgb_directed();
    test_hsl_directed();
    test_random(DIR_TO_HSL, 150);
    test_random(DIR_TO_RGB, 150);
    test_random(DIR_TO_HSL, 40);
    gaps_on = 1'b0;
    test_random(DIR_TO_RGB, 90);
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("Covered %0d RGB->HSL and %0d HSL->RGB pixels, %0d beats checked.",
             n_dir[0], n_dir[1], n_beats);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
